>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the actuator mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside of reset
`define AVPM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every clock edge, reset cycles included
`define AVPM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define AVPM_ASSERT(label, clk, rst_n, prop)
`define AVPM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/avpm_pkg.sv
// ----------------------------------------------------------------------------
// avpm_pkg
// Types, constants and the channel-to-port table of the actuator mapper.
// ----------------------------------------------------------------------------
package avpm_pkg;

    // Channel map
    localparam int unsigned CHANNELS        = 38;
    localparam int unsigned CHAN_W          = 6;
    localparam int unsigned FIRST_BOARD_TWO = 20;
    localparam int unsigned MULT_W          = 5;

    // Field widths
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned STRIDE_W = 8;
    localparam int unsigned CTRL_W   = 16;
    localparam int unsigned RAW_W    = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFS_W   = MULT_W + STRIDE_W;

    // Control value mapping: code = round(sqrt(65025 * (x + 1.0) / 2))
    localparam int unsigned            PROD_W    = 32;
    localparam logic [CTRL_W-1:0]      MAP_SCALE = 16'd65025;
    localparam logic signed [CTRL_W:0] Q_ONE     = 17'sd16384;
    localparam int unsigned            RAD_SHIFT = 13;

    // Integer square root of the scaled product
    localparam int unsigned RAD_W      = 20;
    localparam int unsigned ROOT_W     = RAD_W / 2;
    localparam int unsigned REM_W      = ROOT_W + 1;
    localparam int unsigned SQRT_STEPS = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ONE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TWO_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_STRIDE    = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [ADDR_W-1:0]   BOARD_ONE_RESET = 16'd49152;
    localparam logic [ADDR_W-1:0]   BOARD_TWO_RESET = 16'd50176;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 8'd4;

    // Stream widths
    localparam int unsigned S_TDATA_W = CHAN_W + CTRL_W + RAW_W;
    localparam int unsigned M_TDATA_W = ADDR_W + BYTE_W;

    // Fields that ride alongside the root computation
    typedef struct packed {
        logic                raw_mode;
        logic                chan_err;
        logic [BYTE_W-1:0]   raw_byte;
        logic [ADDR_W-1:0]   base;
        logic [OFFS_W-1:0]   offset;
    } side_t;

    // Partial square root state
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_t;

    typedef struct packed {
        side_t side;
        sqrt_t sq;
    } stage_t;

    // Port multiplier of each channel; substrate and unused slots give zero
    function automatic logic [MULT_W-1:0] port_mult(input logic [CHAN_W-1:0] ch);
        logic [MULT_W-1:0] m;
        unique case (ch)
            6'd1:    m = 5'd13;
            6'd2:    m = 5'd21;
            6'd3:    m = 5'd10;
            6'd4:    m = 5'd14;
            6'd5:    m = 5'd2;
            6'd6:    m = 5'd1;
            6'd7:    m = 5'd9;
            6'd8:    m = 5'd20;
            6'd9:    m = 5'd22;
            6'd10:   m = 5'd11;
            6'd11:   m = 5'd12;
            6'd12:   m = 5'd7;
            6'd13:   m = 5'd4;
            6'd14:   m = 5'd5;
            6'd15:   m = 5'd3;
            6'd16:   m = 5'd0;
            6'd17:   m = 5'd15;
            6'd18:   m = 5'd8;
            6'd19:   m = 5'd23;
            6'd20:   m = 5'd9;
            6'd21:   m = 5'd23;
            6'd22:   m = 5'd22;
            6'd23:   m = 5'd21;
            6'd24:   m = 5'd8;
            6'd25:   m = 5'd4;
            6'd26:   m = 5'd2;
            6'd27:   m = 5'd7;
            6'd28:   m = 5'd5;
            6'd29:   m = 5'd3;
            6'd30:   m = 5'd1;
            6'd31:   m = 5'd0;
            6'd32:   m = 5'd15;
            6'd33:   m = 5'd14;
            6'd34:   m = 5'd13;
            6'd35:   m = 5'd12;
            6'd36:   m = 5'd11;
            6'd37:   m = 5'd10;
            default: m = 5'd0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/avpm_front.sv
// ----------------------------------------------------------------------------
// avpm_front
// First pipeline stage: channel decode, scaling multiply and port offset.
// ----------------------------------------------------------------------------
module avpm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Incoming command
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [avpm_pkg::CHAN_W-1:0]         channel,
    input  logic signed [avpm_pkg::CTRL_W-1:0]  control_value,
    input  logic [avpm_pkg::RAW_W-1:0]          raw_voltage,
    // Board settings
    input  logic [avpm_pkg::ADDR_W-1:0]         board_one_base,
    input  logic [avpm_pkg::ADDR_W-1:0]         board_two_base,
    input  logic [avpm_pkg::STRIDE_W-1:0]       port_stride,
    // Toward the root stages
    output logic                                out_valid,
    input  logic                                out_ready,
    output avpm_pkg::stage_t                    out_data
);

    logic                              valid_reg;
    avpm_pkg::stage_t                  data_reg;
    avpm_pkg::stage_t                  data_next;
    logic                              chan_ok;
    logic                              clamp;
    logic signed [avpm_pkg::CTRL_W:0]  shifted;
    logic [avpm_pkg::PROD_W-1:0]       product;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Decode the command and scale the control value
    always_comb begin
        chan_ok = (channel != '0) && ({26'd0, channel} < avpm_pkg::CHANNELS);
        shifted = {control_value[avpm_pkg::CTRL_W-1], control_value} + avpm_pkg::Q_ONE;
        clamp   = shifted[avpm_pkg::CTRL_W];
        product = {16'd0, shifted[avpm_pkg::CTRL_W-1:0]} * {16'd0, avpm_pkg::MAP_SCALE};

        data_next.side.raw_mode = operation;
        data_next.side.chan_err = !chan_ok;
        data_next.side.raw_byte = raw_voltage[avpm_pkg::BYTE_W-1:0];
        data_next.side.base     = ({26'd0, channel} < avpm_pkg::FIRST_BOARD_TWO) ?
                                  board_one_base : board_two_base;
        data_next.side.offset   = {8'd0, avpm_pkg::port_mult(channel)} *
                                  {5'd0, port_stride};

        data_next.sq.rem  = '0;
        data_next.sq.root = '0;
        data_next.sq.rad  = clamp ? '0 :
                            {1'b0, product[avpm_pkg::PROD_W-1:avpm_pkg::RAD_SHIFT]};
    end

    // Hold the transaction until the next stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/avpm_sqrt_stage.sv
// ----------------------------------------------------------------------------
// avpm_sqrt_stage
// One registered slice of the restoring square root, STEPS root bits per slice.
// ----------------------------------------------------------------------------
module avpm_sqrt_stage #(
    parameter int unsigned STEPS = avpm_pkg::SQRT_STEPS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  avpm_pkg::stage_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output avpm_pkg::stage_t  out_data
);

    localparam int unsigned TRY_W = avpm_pkg::REM_W + 2;

    logic                           valid_reg;
    avpm_pkg::stage_t               data_reg;
    avpm_pkg::stage_t               data_next;
    logic [avpm_pkg::REM_W-1:0]     rem;
    logic [avpm_pkg::ROOT_W-1:0]    root;
    logic [avpm_pkg::RAD_W-1:0]     rad;
    logic [TRY_W-1:0]               part;
    logic [TRY_W-1:0]               trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Resolve STEPS root bits, two radicand bits each
    always_comb begin
        rem   = in_data.sq.rem;
        root  = in_data.sq.root;
        rad   = in_data.sq.rad;
        part  = '0;
        trial = '0;
        for (int i = 0; i < STEPS; i++) begin
            part  = {rem, rad[avpm_pkg::RAD_W-1 -: 2]};
            trial = {1'b0, root, 2'b01};
            if (part >= trial) begin
                part = part - trial;
                root = {root[avpm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                root = {root[avpm_pkg::ROOT_W-2:0], 1'b0};
            end
            rem = part[avpm_pkg::REM_W-1:0];
            rad = {rad[avpm_pkg::RAD_W-3:0], 2'b00};
        end
        data_next.side    = in_data.side;
        data_next.sq.rem  = rem;
        data_next.sq.root = root;
        data_next.sq.rad  = rad;
    end

    // Advance when the next stage has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/actuator_voltage_and_port_mapper.sv
// ----------------------------------------------------------------------------
// actuator_voltage_and_port_mapper
// Maps actuator commands to a driver port address and the byte to write.
// ----------------------------------------------------------------------------
// Usage:
//   s_ carries one command per transaction: channel, control value (Q2.14),
//   raw voltage in tdata and the operation (0 mapped, 1 raw) in tuser.
//   m_ returns one result per command, in order: port address and data byte
//   in tdata, channel error flag in tuser (address and data are zero then).
//   cfg_ writes the board one base, board two base and port stride by
//   index; write it only while no command is in flight. cfg_ready is high.
// Stages: a decode and multiply stage, the square root slices, an output stage.
// Throughput: one command per cycle while the result side accepts; each root slice holds one command.
// Reset: aresetn low empties every stage and restores the register defaults.
// Stall: while m_tready is low the result holds and the stages behind it
//   keep filling; s_tready drops only when every stage holds a command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module actuator_voltage_and_port_mapper #(
    // Root bits resolved per slice: 1, 2, 5 or 10
    parameter int unsigned SQRT_BITS_PER_STAGE = avpm_pkg::SQRT_STEPS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Command stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [5:0] channel, [21:6] control_value, [31:22] raw_voltage
    input  logic [avpm_pkg::S_TDATA_W-1:0]        s_tdata,
    // [0] operation
    input  logic                                  s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] port_address, [23:16] data_byte
    output logic [avpm_pkg::M_TDATA_W-1:0]        m_tdata,
    // [0] channel_error
    output logic                                  m_tuser,
    // Register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [avpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [avpm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned SQRT_STAGES = avpm_pkg::ROOT_W / SQRT_BITS_PER_STAGE;

    logic [avpm_pkg::ADDR_W-1:0]    board_one_base_reg;
    logic [avpm_pkg::ADDR_W-1:0]    board_two_base_reg;
    logic [avpm_pkg::STRIDE_W-1:0]  port_stride_reg;

    logic                           pipe_valid [0:SQRT_STAGES];
    logic                           pipe_ready [0:SQRT_STAGES];
    avpm_pkg::stage_t               pipe_data  [0:SQRT_STAGES];

    logic                           out_valid_reg;
    logic                           out_ready;
    logic [avpm_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [avpm_pkg::M_TDATA_W-1:0] out_data_next;
    logic                           out_err_reg;
    logic [avpm_pkg::ROOT_W:0]      rounded;
    logic [avpm_pkg::BYTE_W-1:0]    code;
    logic [avpm_pkg::ADDR_W-1:0]    address;
    avpm_pkg::stage_t               last;

    // Register writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_one_base_reg <= avpm_pkg::BOARD_ONE_RESET;
            board_two_base_reg <= avpm_pkg::BOARD_TWO_RESET;
            port_stride_reg    <= avpm_pkg::STRIDE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                avpm_pkg::CFG_BOARD_ONE_BASE: board_one_base_reg <= cfg_data;
                avpm_pkg::CFG_BOARD_TWO_BASE: board_two_base_reg <= cfg_data;
                avpm_pkg::CFG_PORT_STRIDE:
                    port_stride_reg <= cfg_data[avpm_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode and scale
    avpm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .operation      (s_tuser),
        .channel        (s_tdata[5:0]),
        .control_value  (s_tdata[21:6]),
        .raw_voltage    (s_tdata[31:22]),
        .board_one_base (board_one_base_reg),
        .board_two_base (board_two_base_reg),
        .port_stride    (port_stride_reg),
        .out_valid      (pipe_valid[0]),
        .out_ready      (pipe_ready[0]),
        .out_data       (pipe_data[0])
    );

    // Square root slices
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        avpm_sqrt_stage #(
            .STEPS (SQRT_BITS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_data   (pipe_data[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_data  (pipe_data[g+1])
        );
    end

    // Round the root or take the raw byte, add the port offset, zero errored results
    assign out_ready            = !out_valid_reg || m_tready;
    assign pipe_ready[SQRT_STAGES] = out_ready;
    assign last                 = pipe_data[SQRT_STAGES];

    always_comb begin
        rounded = {1'b0, last.sq.root} + {{avpm_pkg::ROOT_W{1'b0}}, 1'b1};
        code    = last.side.raw_mode ? last.side.raw_byte :
                  rounded[avpm_pkg::BYTE_W:1];
        address = last.side.base + {3'd0, last.side.offset};
        out_data_next = last.side.chan_err ? '0 : {code, address};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= pipe_valid[SQRT_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && pipe_valid[SQRT_STAGES]) begin
            out_data_reg <= out_data_next;
            out_err_reg  <= last.side.chan_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // Checks
    `AVPM_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !m_tvalid)
    `AVPM_ASSERT(a_error_result_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0)
    `AVPM_ASSERT(a_backpressure_only_when_full, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the actuator voltage and port mapper. Commands are
// streamed in with random gaps and back-pressure under several board/stride
// settings; a scoreboard predicts the port address, data byte and channel
// error flag of every accepted command and checks the results in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import avpm_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 205;

    typedef enum logic {
        OP_MAPPED = 1'b0,
        OP_RAW    = 1'b1
    } op_e;

    typedef struct {
        op_e                    op;
        logic [CHAN_W-1:0]      chan;
        logic signed [CTRL_W-1:0] ctrl;
        logic [RAW_W-1:0]       raw;
    } command_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] code;
        logic              err;
    } port_write_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, prediction and in-order result check
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        logic [ADDR_W-1:0]   board_one;
        logic [ADDR_W-1:0]   board_two;
        logic [STRIDE_W-1:0] stride;
        int unsigned         failures;
        port_write_t         pending_writes[$];

        // Stride multiplier of each valid channel, substrate at index 0
        int unsigned port_step[CHANNELS] = '{
            0,
            13, 21, 10, 14, 2, 1, 9, 20, 22, 11, 12, 7, 4, 5, 3, 0, 15, 8, 23,
            9, 23, 22, 21, 8, 4, 2, 7, 5, 3, 1, 0, 15, 14, 13, 12, 11, 10
        };

        function new();
            board_one = BOARD_ONE_RESET;
            board_two = BOARD_TWO_RESET;
            stride    = STRIDE_RESET;
            failures  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BOARD_ONE_BASE: board_one = data;
                CFG_BOARD_TWO_BASE: board_two = data;
                CFG_PORT_STRIDE:    stride    = data[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        // round(sqrt(65025 * (x + 1) / 2)), clamped below -1, wrapped to 8 bits
        function logic [BYTE_W-1:0] voltage_code(logic signed [CTRL_W-1:0] x);
            longint unsigned scaled;
            longint unsigned odd;
            int unsigned     n;
            if (x < -16'sd16384)
                return '0;
            scaled = 64'd65025 * longint'(int'(x) + 16384);
            n = 0;
            odd = 1;
            while (n < 1023 && scaled >= 64'd8192 * odd * odd) begin
                n++;
                odd = 2 * n + 1;
            end
            return n[BYTE_W-1:0];
        endfunction

        function int unsigned pending();
            return pending_writes.size();
        endfunction

        function void note_command(command_t c);
            port_write_t w;
            int unsigned sum;
            if (c.chan == 0 || c.chan >= CHANNELS) begin
                w.addr = '0;
                w.code = '0;
                w.err  = 1'b1;
            end else begin
                sum = (c.chan < FIRST_BOARD_TWO) ? board_one : board_two;
                sum = sum + port_step[c.chan] * stride;
                w.addr = sum[ADDR_W-1:0];
                w.code = (c.op == OP_MAPPED) ? voltage_code(c.ctrl) : c.raw[BYTE_W-1:0];
                w.err  = 1'b0;
            end
            pending_writes.push_back(w);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            port_write_t w;
            if (pending_writes.size() == 0) begin
                $error("unexpected result: port_address %0d, data_byte %0d, channel_error %0d",
                       tdata[ADDR_W-1:0], tdata[ADDR_W +: BYTE_W], tuser);
                failures++;
                return;
            end
            w = pending_writes.pop_front();
            if (tdata[ADDR_W-1:0] !== w.addr) begin
                $error("port_address: expected %0d, got %0d", w.addr, tdata[ADDR_W-1:0]);
                failures++;
            end
            if (tdata[ADDR_W +: BYTE_W] !== w.code) begin
                $error("data_byte: expected %0d, got %0d", w.code, tdata[ADDR_W +: BYTE_W]);
                failures++;
            end
            if (tuser !== w.err) begin
                $error("channel_error: expected %0d, got %0d", w.err, tuser);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [5:0] channel, [21:6] control_value, [31:22] raw_voltage
    logic                   s_tuser;    // [0] operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [15:0] port_address, [23:16] data_byte
    logic                   m_tuser;    // [0] channel_error
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mapper_scoreboard sb;
    bit               no_idle;
    bit               hold_request;
    int unsigned      hold_left;
    int unsigned      cycle_count;

    actuator_voltage_and_port_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive m_tready: random stalls, steady stretches and one long hold-off
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (no_idle) begin
            m_tready = 1'b1;
        end else begin
            m_tready = ($urandom_range(99) >= 19);
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Offer one command and hold it until the transaction completes
    task automatic send_command(command_t c);
        s_tvalid = 1'b1;
        s_tdata  = {c.raw, c.ctrl, c.chan};
        s_tuser  = c.op;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
        @(negedge aclk);
    endtask

    task automatic send_fields(op_e op, int unsigned chan, int ctrl, int unsigned raw);
        command_t c;
        c.op   = op;
        c.chan = chan[CHAN_W-1:0];
        c.ctrl = ctrl[CTRL_W-1:0];
        c.raw  = raw[RAW_W-1:0];
        send_command(c);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic command_t random_command();
        command_t c;
        c.op = op_e'($urandom_range(1));
        if ($urandom_range(9) == 0)
            c.chan = ($urandom_range(1) == 0) ? '0 : CHAN_W'($urandom_range(63, CHANNELS));
        else
            c.chan = CHAN_W'($urandom_range(CHANNELS - 1, 1));
        // Mostly the nominal -1.0 .. +1.0 range, sometimes any code
        if ($urandom_range(3) == 0)
            c.ctrl = CTRL_W'($urandom);
        else
            c.ctrl = CTRL_W'(int'($urandom_range(32768)) - 16384);
        c.raw = RAW_W'($urandom_range(1023));
        return c;
    endfunction

    task automatic run_commands(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            while (!no_idle && $urandom_range(99) < 19) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            send_command(random_command());
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        sb           = new();
        no_idle      = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        // Hold reset across rising edges, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: invalid channels, board edges, clamp, rounding and wrap
        send_fields(OP_MAPPED, 0, 0, 0);
        send_fields(OP_RAW, 0, 16384, 255);
        send_fields(OP_MAPPED, 38, 0, 0);
        send_fields(OP_RAW, 63, -1, 1023);
        send_fields(OP_MAPPED, 1, -32768, 1023);
        send_fields(OP_MAPPED, 19, -16385, 0);
        send_fields(OP_MAPPED, 20, -16384, 0);
        send_fields(OP_MAPPED, 37, -16383, 0);
        send_fields(OP_MAPPED, 16, 0, 0);
        send_fields(OP_MAPPED, 31, -1, 0);
        send_fields(OP_MAPPED, 2, 1, 0);
        send_fields(OP_MAPPED, 21, 16384, 0);
        send_fields(OP_MAPPED, 9, 16385, 0);
        send_fields(OP_MAPPED, 22, 24576, 0);
        send_fields(OP_MAPPED, 8, 32767, 0);
        send_fields(OP_RAW, 5, 0, 0);
        send_fields(OP_RAW, 6, 0, 255);
        send_fields(OP_RAW, 30, 0, 256);
        send_fields(OP_RAW, 36, -32768, 1023);
        send_fields(OP_RAW, 19, 32767, 511);
        drain();

        // Address wrap; stride data carries upper bits that must drop.
        // Hold the result side off so the pipeline fills and stalls input.
        write_register(CFG_BOARD_ONE_BASE, 16'h0000);
        write_register(CFG_BOARD_TWO_BASE, 16'hFFFF);
        write_register(CFG_PORT_STRIDE, 16'hA5FF);
        hold_request = 1'b1;
        run_commands(PHASE_ITEMS);
        drain();

        // Zero stride, unused index ignored; no idling on either side
        write_register(CFG_BOARD_ONE_BASE, 16'hFFFF);
        write_register(CFG_BOARD_TWO_BASE, 16'h0000);
        write_register(CFG_PORT_STRIDE, 16'h0000);
        write_register(CFG_UNUSED, 16'h1234);
        no_idle = 1'b1;
        run_commands(PHASE_ITEMS);
        drain();
        no_idle = 1'b0;

        // Random settings; pause once mid-phase until all results are back
        for (int p = 0; p < 3; p++) begin
            write_register(CFG_BOARD_ONE_BASE, CFG_DATA_W'($urandom));
            write_register(CFG_BOARD_TWO_BASE, CFG_DATA_W'($urandom));
            write_register(CFG_PORT_STRIDE, CFG_DATA_W'($urandom));
            run_commands(PHASE_ITEMS / 2);
            if (p == 1)
                drain();
            run_commands(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        // Back to the reset values
        write_register(CFG_BOARD_ONE_BASE, BOARD_ONE_RESET);
        write_register(CFG_BOARD_TWO_BASE, BOARD_TWO_RESET);
        write_register(CFG_PORT_STRIDE, CFG_DATA_W'(STRIDE_RESET));
        run_commands(PHASE_ITEMS);
        drain();

        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/avpm_pkg.sv
rtl/avpm_front.sv
rtl/avpm_sqrt_stage.sv
rtl/actuator_voltage_and_port_mapper.sv
tb/tb_top.sv
